[rtl/core/matrix_vector_multiply_defines.svh]
// ---------------------------------------------------------------------------
// Matrix-vector multiply assertion macros
// Shared concurrent assertion forms for the checker of the block.
// ---------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define MVM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matrix_vector_multiply: same-cycle check failed");

// Next-cycle implication, off while reset is asserted
`define MVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matrix_vector_multiply: next-cycle check failed");

`endif

[rtl/core/mvm_pkg.sv]
// ---------------------------------------------------------------------------
// Matrix-vector multiply package
// Item types, register indexes, FSM states and controller/datapath structs.
// ---------------------------------------------------------------------------
package mvm_pkg;

  // Fixed field widths
  localparam int IDX_W     = 4;
  localparam int DATA_W    = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = 40;
  localparam int RES_W     = 32;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 5;
  // Row select in commands, wide enough for the largest supported row count
  localparam int ROW_SEL_W = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 4'd1;

  // Input item kinds
  localparam logic KIND_WEIGHT  = 1'b0;
  localparam logic KIND_ELEMENT = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic signed [RES_W-1:0] result_value;
    logic                    last;
    logic                    dim_error;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMIT,
    ST_ERR
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic                 weight_we;
    logic                 elem_load;
    logic                 rd_en;
    logic [ROW_SEL_W-1:0] rd_row;
    logic                 emit;
    logic [ROW_SEL_W-1:0] emit_row;
    logic                 emit_last;
    logic                 err_emit;
    logic                 clear_all;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

[rtl/core/mvm_chan_if.sv]
// ---------------------------------------------------------------------------
// Matrix-vector multiply channel
// Valid/ready channel carrying one item of a given payload type.
// ---------------------------------------------------------------------------
interface mvm_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

[rtl/core/mvm_ctrl.sv]
// ---------------------------------------------------------------------------
// Matrix-vector multiply controller
// Config registers, element order check, row sequencing and result emission.
// ---------------------------------------------------------------------------
module mvm_ctrl #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  mvm_pkg::in_item_t   in_payload_i,
  output logic                in_ready_o,
  input  logic                cfg_valid_i,
  input  mvm_pkg::cfg_item_t  cfg_payload_i,
  output logic                cfg_ready_o,
  input  mvm_pkg::sts_t       sts_i,
  output mvm_pkg::cmd_t       cmd_o
);

  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);
  localparam int CNT_W  = $clog2(MAX_ROWS + 2);
  localparam int CMP_W  = ((CCNT_W > mvm_pkg::IDX_W) ? CCNT_W : mvm_pkg::IDX_W) + 1;
  localparam int RESET_ROWS = (MAX_ROWS < 16) ? MAX_ROWS : 16;
  localparam int RESET_COLS = (MAX_COLS < 16) ? MAX_COLS : 16;

  mvm_pkg::state_e   state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CCNT_W-1:0] next_elem_q, next_elem_d;
  logic              final_q, final_d;
  logic [RCNT_W-1:0] rows_q, rows_d;
  logic [CCNT_W-1:0] cols_q, cols_d;

  logic [CMP_W-1:0]  col_ext;
  logic [CMP_W-1:0]  next_ext;
  logic [CMP_W-1:0]  cols_ext;
  logic              elem_bad;
  logic              elem_final;
  logic              elem_acc;
  logic              mac_done;
  logic              emit_last;
  int                cfg_val;

  // Element checks against expected index and column count
  assign col_ext    = CMP_W'(in_payload_i.col_index);
  assign next_ext   = CMP_W'(next_elem_q);
  assign cols_ext   = CMP_W'(cols_q);
  assign elem_bad   = (col_ext != next_ext) || (col_ext >= cols_ext);
  assign elem_final = ((col_ext + CMP_W'(1)) == cols_ext);
  assign elem_acc   = in_valid_i && (state_q == mvm_pkg::ST_IDLE) &&
                      (in_payload_i.kind == mvm_pkg::KIND_ELEMENT);

  // Sequencing status
  assign mac_done  = (cnt_q == (CNT_W'(rows_q) + CNT_W'(1)));
  assign emit_last = ((cnt_q + CNT_W'(1)) == CNT_W'(rows_q));
  assign cfg_val   = int'(cfg_payload_i.data);

  // Next state, counters and config registers
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    next_elem_d = next_elem_q;
    final_d     = final_q;
    rows_d      = rows_q;
    cols_d      = cols_q;

    if (cfg_valid_i) begin
      if (cfg_payload_i.reg_index == mvm_pkg::CFG_ROWS_IN_USE) begin
        if (cfg_val < 1) begin
          rows_d = RCNT_W'(1);
        end else if (cfg_val > MAX_ROWS) begin
          rows_d = RCNT_W'(MAX_ROWS);
        end else begin
          rows_d = RCNT_W'(cfg_val);
        end
      end else if (cfg_payload_i.reg_index == mvm_pkg::CFG_COLS_IN_USE) begin
        if (cfg_val < 1) begin
          cols_d = CCNT_W'(1);
        end else if (cfg_val > MAX_COLS) begin
          cols_d = CCNT_W'(MAX_COLS);
        end else begin
          cols_d = CCNT_W'(cfg_val);
        end
      end
    end

    unique case (state_q)
      mvm_pkg::ST_IDLE: begin
        if (elem_acc) begin
          if (elem_bad) begin
            state_d = mvm_pkg::ST_ERR;
          end else begin
            state_d = mvm_pkg::ST_MAC;
            cnt_d   = '0;
            final_d = elem_final;
          end
        end
      end
      mvm_pkg::ST_MAC: begin
        if (mac_done) begin
          cnt_d = '0;
          if (final_q) begin
            state_d     = mvm_pkg::ST_EMIT;
            next_elem_d = '0;
          end else begin
            state_d     = mvm_pkg::ST_IDLE;
            next_elem_d = next_elem_q + CCNT_W'(1);
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      mvm_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          if (emit_last) begin
            state_d = mvm_pkg::ST_IDLE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      mvm_pkg::ST_ERR: begin
        if (sts_i.out_free) begin
          state_d     = mvm_pkg::ST_IDLE;
          next_elem_d = '0;
        end
      end
      default: state_d = mvm_pkg::ST_IDLE;
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b1;

    unique case (state_q)
      mvm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (in_payload_i.kind == mvm_pkg::KIND_WEIGHT)) begin
          cmd_o.weight_we = 1'b1;
        end
        cmd_o.elem_load = elem_acc && !elem_bad;
      end
      mvm_pkg::ST_MAC: begin
        cmd_o.rd_en  = (cnt_q < CNT_W'(rows_q));
        cmd_o.rd_row = mvm_pkg::ROW_SEL_W'(cnt_q);
      end
      mvm_pkg::ST_EMIT: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.emit_row  = mvm_pkg::ROW_SEL_W'(cnt_q);
        cmd_o.emit_last = emit_last;
        cmd_o.clear_all = sts_i.out_free && emit_last;
      end
      mvm_pkg::ST_ERR: begin
        cmd_o.err_emit  = sts_i.out_free;
        cmd_o.clear_all = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mvm_pkg::ST_IDLE;
      cnt_q       <= '0;
      next_elem_q <= '0;
      final_q     <= 1'b0;
      rows_q      <= RCNT_W'(RESET_ROWS);
      cols_q      <= CCNT_W'(RESET_COLS);
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      next_elem_q <= next_elem_d;
      final_q     <= final_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
    end
  end

endmodule

[rtl/core/mvm_dp.sv]
// ---------------------------------------------------------------------------
// Matrix-vector multiply datapath
// Weight memory, shared multiply-accumulate, row accumulators, output register.
// ---------------------------------------------------------------------------
module mvm_dp #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mvm_pkg::in_item_t  in_payload_i,
  input  mvm_pkg::cmd_t      cmd_i,
  output mvm_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mvm_pkg::out_item_t out_payload_o
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SUM_W  = mvm_pkg::ACC_W + 1;
  localparam logic signed [mvm_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(mvm_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [mvm_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(mvm_pkg::ACC_W-1){1'b0}}};
  localparam logic signed [mvm_pkg::RES_W-1:0] RES_MAX = {1'b0, {(mvm_pkg::RES_W-1){1'b1}}};
  localparam logic signed [mvm_pkg::RES_W-1:0] RES_MIN = {1'b1, {(mvm_pkg::RES_W-1){1'b0}}};

  logic signed [mvm_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [mvm_pkg::DATA_W-1:0] rdata_q;
  logic signed [mvm_pkg::DATA_W-1:0] elem_q;
  logic [mvm_pkg::IDX_W-1:0]         col_q;
  logic                              v1_q, v2_q;
  logic [ROW_W-1:0]                  row1_q, row2_q;
  logic signed [mvm_pkg::PROD_W-1:0] prod_q;
  logic signed [mvm_pkg::ACC_W-1:0]  acc_q [MAX_ROWS];
  logic signed [SUM_W-1:0]           acc_sum;
  logic signed [mvm_pkg::ACC_W-1:0]  acc_sat;
  logic signed [mvm_pkg::ACC_W-1:0]  emit_acc;
  logic signed [mvm_pkg::RES_W-1:0]  emit_res;
  logic                              wr_in_range;
  logic [ADDR_W-1:0]                 waddr;
  logic [ADDR_W-1:0]                 raddr;
  logic                              out_valid_q;
  mvm_pkg::out_item_t                out_q;

  // Weight addressing, row-major
  assign wr_in_range = (int'(in_payload_i.row_index) < MAX_ROWS) &&
                       (int'(in_payload_i.col_index) < MAX_COLS);
  assign waddr = ADDR_W'(int'(in_payload_i.row_index) * MAX_COLS +
                         int'(in_payload_i.col_index));
  assign raddr = ADDR_W'(int'(cmd_i.rd_row[ROW_W-1:0]) * MAX_COLS + int'(col_q));

  // Weight memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.weight_we && wr_in_range) begin
      mem[waddr] <= in_payload_i.value;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // Element latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.elem_load) begin
      elem_q <= in_payload_i.value;
      col_q  <= in_payload_i.col_index;
    end
  end

  // Product stage
  always_ff @(posedge clk_i) begin
    prod_q <= rdata_q * elem_q;
  end

  // Row tags through the MAC pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    row1_q <= cmd_i.rd_row[ROW_W-1:0];
    row2_q <= row1_q;
  end

  // Saturating accumulate
  always_comb begin
    acc_sum = SUM_W'(acc_q[row2_q]) + SUM_W'(prod_q);
    if (acc_sum > SUM_W'(ACC_MAX)) begin
      acc_sat = ACC_MAX;
    end else if (acc_sum < SUM_W'(ACC_MIN)) begin
      acc_sat = ACC_MIN;
    end else begin
      acc_sat = acc_sum[mvm_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ROWS; i++) begin
        acc_q[i] <= '0;
      end
    end else if (cmd_i.clear_all) begin
      for (int i = 0; i < MAX_ROWS; i++) begin
        acc_q[i] <= '0;
      end
    end else if (v2_q) begin
      acc_q[row2_q] <= acc_sat;
    end
  end

  // Result saturation to Q16.16
  always_comb begin
    emit_acc = acc_q[cmd_i.emit_row[ROW_W-1:0]];
    if (emit_acc > mvm_pkg::ACC_W'(RES_MAX)) begin
      emit_res = RES_MAX;
    end else if (emit_acc < mvm_pkg::ACC_W'(RES_MIN)) begin
      emit_res = RES_MIN;
    end else begin
      emit_res = emit_acc[mvm_pkg::RES_W-1:0];
    end
  end

  // Output register
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.err_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.out_row      <= cmd_i.emit_row[mvm_pkg::IDX_W-1:0];
      out_q.result_value <= emit_res;
      out_q.last         <= cmd_i.emit_last;
      out_q.dim_error    <= 1'b0;
    end else if (cmd_i.err_emit) begin
      out_q.out_row      <= '0;
      out_q.result_value <= '0;
      out_q.last         <= 1'b1;
      out_q.dim_error    <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_q;

endmodule

[rtl/core/matrix_vector_multiply.sv]
// A weight write is taken while the controller is idle. A vector element
// is accepted, then passes once per row through the single shared
// multiply-accumulate (one weight memory read per row), after which the
// read and multiply stages drain. The element with the final column index
// then emits one result per row, at one per cycle while the output side
// takes them. An out-of-order element yields one error result. The output
// register lets a finished result wait while the next item is taken in.
// ---------------------------------------------------------------------------
// Matrix-vector multiply top level
// Column-wise accumulating matrix-vector product, Q8.8 in, Q16.16 out.
// ---------------------------------------------------------------------------
module matrix_vector_multiply #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  mvm_chan_if.sink        in_if,
  mvm_chan_if.source      out_if,
  mvm_chan_if.sink        cfg_if
);

  mvm_pkg::cmd_t      cmd;
  mvm_pkg::sts_t      sts;
  mvm_pkg::in_item_t  in_payload;
  mvm_pkg::cfg_item_t cfg_payload;
  mvm_pkg::out_item_t out_payload;
  logic               in_ready;
  logic               cfg_ready;
  logic               out_valid;

  assign in_payload     = in_if.payload;
  assign cfg_payload    = cfg_if.payload;
  assign in_if.ready    = in_ready;
  assign cfg_if.ready   = cfg_ready;
  assign out_if.valid   = out_valid;
  assign out_if.payload = out_payload;

  mvm_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_mvm_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_if.valid),
    .in_payload_i  (in_payload),
    .in_ready_o    (in_ready),
    .cfg_valid_i   (cfg_if.valid),
    .cfg_payload_i (cfg_payload),
    .cfg_ready_o   (cfg_ready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  mvm_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_mvm_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_payload_i  (in_payload),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_if.ready),
    .out_payload_o (out_payload)
  );

endmodule

[rtl/core/mvm_checker.sv]
// ---------------------------------------------------------------------------
// Matrix-vector multiply port checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "matrix_vector_multiply_defines.svh"

module mvm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input mvm_pkg::in_item_t  in_payload_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input mvm_pkg::out_item_t out_payload_i
);

  logic elem_acc;
  logic out_stall;
  logic err_shape;

  assign elem_acc  = in_valid_i && in_ready_i &&
                     (in_payload_i.kind == mvm_pkg::KIND_ELEMENT);
  assign out_stall = out_valid_i && !out_ready_i;
  assign err_shape = out_payload_i.last && (out_payload_i.out_row == '0) &&
                     (out_payload_i.result_value == '0);

  // A stalled result stays offered
  `MVM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i)

  // A stalled result keeps its payload
  `MVM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(out_payload_i))

  // An error result is a lone, zero, final item
  `MVM_ASSERT_SAME(a_err_shape, clk_i, rst_ni, out_valid_i && out_payload_i.dim_error, err_shape)

  // An element is processed alone: input closes right after it is taken
  `MVM_ASSERT_NEXT(a_elem_busy, clk_i, rst_ni, elem_acc, !in_ready_i)

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .in_payload_i  (in_if.payload),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .out_payload_i (out_if.payload)
);
